/* rtl/twc_pkg.sv */
// Shared types, constants and helper functions for the weighted centroid block.
`timescale 1ns / 1ps
package twc_pkg;

    // Frame size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field and accumulator widths
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int BRIGHT_W   = 25;
    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 45;
    localparam int TAG_W      = 32;
    localparam int CENTRE_W   = 20;
    localparam int CONF_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int QUOT_W     = SUM_W + 8;
    localparam int DVSR_W     = 32;
    localparam int NINE_W     = BRIGHT_W + 4;
    localparam int PROD_W     = BRIGHT_W + GAIN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(65536);

    // Pixel format codes
    localparam logic [1:0] FMT_GREY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_BGR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd5;

    // Register reset values
    localparam logic [1:0]          DEF_FORMAT    = FMT_GREY;
    localparam logic [DIM_W-1:0]    DEF_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]    DEF_HEIGHT    = 13'd480;
    localparam logic [7:0]          DEF_THRESHOLD = 8'd200;
    localparam logic [BRIGHT_W-1:0] DEF_MIN_COUNT = 25'd10;
    localparam logic [GAIN_W-1:0]   DEF_GAIN      = 16'd256;

    typedef struct packed {
        logic [1:0]          pixel_format;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [7:0]          intensity_threshold;
        logic [BRIGHT_W-1:0] min_bright_pixels;
        logic [GAIN_W-1:0]   confidence_gain;
    } twc_cfg_t;

    typedef struct packed {
        logic [7:0]       byte_a;
        logic [7:0]       byte_b;
        logic [7:0]       byte_c;
        logic [TAG_W-1:0] frame_tag;
    } twc_in_t;

    typedef struct packed {
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
        logic [CONF_W-1:0]   confidence;
        logic                found;
        logic [TAG_W-1:0]    result_tag;
    } twc_out_t;

    // Frame totals handed from the front to the back
    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic [WEIGHT_W-1:0] weight;
        logic [SUM_W-1:0]    wx;
        logic [SUM_W-1:0]    wy;
        logic [TAG_W-1:0]    tag;
    } twc_snap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_C,
        ST_SEND
    } twc_state_t;

    // Reduce a pixel to its grey level
    function automatic logic [7:0] grey_of(input logic [1:0] fmt, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
        logic [15:0] sum;
        sum = 16'd0;
        case (fmt)
            FMT_GREY: sum = {a, 8'd0};
            FMT_RGB:  sum = 16'(16'd77 * a) + 16'(16'd150 * b) + 16'(16'd29 * c);
            FMT_BGR:  sum = 16'(16'd77 * c) + 16'(16'd150 * b) + 16'(16'd29 * a);
            default:  sum = 16'd0;
        endcase
        return sum[15:8];
    endfunction

    // Clamp a frame dimension to 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

/* rtl/twc_front.sv */
// Front end: raster position tracking, grey conversion and frame accumulation.
`timescale 1ns / 1ps
module twc_front #(
    parameter int MAX_WIDTH  = twc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = twc_pkg::DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  twc_pkg::twc_in_t   in_data,
    input  twc_pkg::twc_cfg_t  cfg,
    output logic               last_pending,
    output logic               push,
    output twc_pkg::twc_snap_t snap
);
    import twc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                p1_valid_reg;
    logic                p1_last_reg;
    logic [7:0]          p1_grey_reg;
    logic [COL_W-1:0]    p1_col_reg;
    logic [ROW_W-1:0]    p1_row_reg;
    logic [TAG_W-1:0]    p1_tag_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SUM_W-1:0]    wx_reg;
    logic [SUM_W-1:0]    wy_reg;

    logic [DIM_W-1:0]    last_col;
    logic [DIM_W-1:0]    last_row;
    logic                col_end;
    logic                row_end;
    logic                hit;
    logic [8+COL_W-1:0]  xprod;
    logic [8+ROW_W-1:0]  yprod;
    logic [BRIGHT_W-1:0] bright_next;
    logic [WEIGHT_W-1:0] weight_next;
    logic [SUM_W-1:0]    wx_next;
    logic [SUM_W-1:0]    wy_next;

    // Last column and row of the frame
    assign last_col = clamp_dim(cfg.frame_width, DIM_W'(MAX_WIDTH)) - DIM_W'(1);
    assign last_row = clamp_dim(cfg.frame_height, DIM_W'(MAX_HEIGHT)) - DIM_W'(1);
    assign col_end  = DIM_W'(col_reg) >= last_col;
    assign row_end  = DIM_W'(row_reg) >= last_row;

    // Advance the raster position on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            if (accept) begin
                if (col_end) begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Hold the pixel for the accumulate stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_grey_reg <= grey_of(cfg.pixel_format, in_data.byte_a, in_data.byte_b,
                                   in_data.byte_c);
            p1_col_reg  <= col_reg;
            p1_row_reg  <= row_reg;
            p1_last_reg <= col_end && row_end;
            p1_tag_reg  <= in_data.frame_tag;
        end
    end

    // Add bright pixels into the frame totals
    assign hit   = p1_valid_reg && (p1_grey_reg >= cfg.intensity_threshold);
    assign xprod = p1_grey_reg * p1_col_reg;
    assign yprod = p1_grey_reg * p1_row_reg;

    always_comb begin
        bright_next = bright_reg;
        weight_next = weight_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        if (hit) begin
            bright_next = bright_reg + BRIGHT_W'(1);
            weight_next = weight_reg + WEIGHT_W'(p1_grey_reg);
            wx_next     = wx_reg + SUM_W'(xprod);
            wy_next     = wy_reg + SUM_W'(yprod);
        end
    end

    assign push         = p1_valid_reg && p1_last_reg;
    assign last_pending = push;
    assign snap         = '{bright: bright_next, weight: weight_next, wx: wx_next,
                            wy: wy_next, tag: p1_tag_reg};

    // Clear the totals once the frame is handed off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= '0;
            weight_reg <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
        end else if (push) begin
            bright_reg <= '0;
            weight_reg <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
        end else begin
            bright_reg <= bright_next;
            weight_reg <= weight_next;
            wx_reg     <= wx_next;
            wy_reg     <= wy_next;
        end
    end

endmodule

/* rtl/twc_queue.sv */
// Short queue of frame totals between the front and the back.
`timescale 1ns / 1ps
module twc_queue #(
    parameter int DEPTH = twc_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  twc_pkg::twc_snap_t           push_data,
    input  logic                         pop,
    output logic                         out_valid,
    output twc_pkg::twc_snap_t           out_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import twc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twc_snap_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // Move the pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

/* rtl/twc_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all per-frame divisions.
`timescale 1ns / 1ps
module twc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [twc_pkg::QUOT_W-1:0]   dividend,
    input  logic [twc_pkg::DVSR_W-1:0]   divisor,
    output logic                         done,
    output logic [twc_pkg::QUOT_W-1:0]   quotient
);
    import twc_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] dvd_reg;
    logic [QUOT_W-1:0] quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [DVSR_W:0]   trial;
    logic              fits;
    logic [DVSR_W:0]   diff;

    // Shift in one dividend bit and try the subtract
    assign trial = {rem_reg, dvd_reg[QUOT_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};
    assign diff  = trial - {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(QUOT_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= cnt_reg == CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dvsr_reg <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[QUOT_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quo_reg <= {quo_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/twc_back.sv */
// Back end: per-frame centroid and confidence sequencer with the result register.
`timescale 1ns / 1ps
module twc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  twc_pkg::twc_snap_t q_data,
    output logic               q_pop,
    input  twc_pkg::twc_cfg_t  cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output twc_pkg::twc_out_t  m_data
);
    import twc_pkg::*;

    twc_state_t          state_reg;
    twc_state_t          state_next;
    twc_snap_t           snap_reg;
    logic [BRIGHT_W-1:0] d_reg;
    logic [NINE_W-1:0]   nine_m_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CENTRE_W-1:0] cx_reg;
    logic [CENTRE_W-1:0] cy_reg;
    logic [CONF_W-1:0]   conf_reg;
    logic                found_reg;
    logic                m_valid_reg;
    twc_out_t            m_data_reg;

    logic                found_c;
    logic [BRIGHT_W-1:0] m_c;
    logic [NINE_W-1:0]   nine_m_c;
    logic [BRIGHT_W-1:0] d_raw;
    logic [BRIGHT_W-1:0] d_c;
    logic                div_start;
    logic [QUOT_W-1:0]   div_dividend;
    logic [DVSR_W-1:0]   div_divisor;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                out_load;

    // Trust test and clamped excess count
    assign found_c  = (snap_reg.bright >= cfg.min_bright_pixels) && (snap_reg.weight != '0);
    assign m_c      = (cfg.min_bright_pixels == '0) ? BRIGHT_W'(1) : cfg.min_bright_pixels;
    assign nine_m_c = {m_c, 3'b000} + NINE_W'(m_c);
    assign d_raw    = (snap_reg.bright >= m_c) ? snap_reg.bright - m_c : '0;
    assign d_c      = (NINE_W'(d_raw) > nine_m_c) ? nine_m_c[BRIGHT_W-1:0] : d_raw;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_PREP;
            ST_PREP:  state_next = found_c ? ST_DIV_X : ST_SEND;
            ST_DIV_X: if (div_done) state_next = ST_DIV_Y;
            ST_DIV_Y: if (div_done) state_next = ST_DIV_C;
            ST_DIV_C: if (div_done) state_next = ST_SEND;
            ST_SEND:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Queue pop, divider launch and result load
    always_comb begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_PREP: begin
                div_start    = found_c;
                div_dividend = {snap_reg.wx, 8'd0};
                div_divisor  = snap_reg.weight;
            end
            ST_DIV_X: begin
                div_start    = div_done;
                div_dividend = {snap_reg.wy, 8'd0};
                div_divisor  = snap_reg.weight;
            end
            ST_DIV_Y: begin
                div_start    = div_done;
                div_dividend = QUOT_W'({prod_reg, 8'd0});
                div_divisor  = DVSR_W'(nine_m_reg);
            end
            ST_SEND: out_load = !m_valid_reg || m_ready;
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the frame and the division results
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            snap_reg <= q_data;
        end
        if (state_reg == ST_PREP) begin
            found_reg  <= found_c;
            d_reg      <= d_c;
            nine_m_reg <= nine_m_c;
            if (!found_c) begin
                cx_reg   <= '0;
                cy_reg   <= '0;
                conf_reg <= '0;
            end
        end
        if (state_reg == ST_DIV_X) begin
            prod_reg <= d_reg * cfg.confidence_gain;
            if (div_done) begin
                cx_reg <= div_quot[CENTRE_W-1:0];
            end
        end
        if (state_reg == ST_DIV_Y && div_done) begin
            cy_reg <= div_quot[CENTRE_W-1:0];
        end
        if (state_reg == ST_DIV_C && div_done) begin
            conf_reg <= (div_quot > QUOT_W'(CONF_ONE)) ? CONF_ONE : div_quot[CONF_W-1:0];
        end
    end

    twc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= '{centre_x: cx_reg, centre_y: cy_reg, confidence: conf_reg,
                            found: found_reg, result_tag: snap_reg.tag};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/thresholded_weighted_centroid_top.sv */
// Thresholded intensity-weighted centroid: top level with register file and assertions.
// Throughput: one pixel per cycle while the frame-total queue has room.
// A trusted frame's result passes the queue entry, the prepare state and three divider
// passes (centre x, centre y, confidence); an untrusted one skips the divisions.
// Frames shorter than the back end's work fill the two-entry queue and then pause s_ready.
// Reset (aresetn low, synchronous) restores register defaults and clears all counters.
`timescale 1ns / 1ps
module thresholded_weighted_centroid_top #(
    parameter int MAX_WIDTH  = twc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = twc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  twc_pkg::twc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output twc_pkg::twc_out_t                 m_data,
    input  logic                              cfg_wen,
    input  logic [twc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import twc_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    twc_cfg_t         cfg_reg;
    logic             accept;
    logic             last_pending;
    logic             q_push;
    twc_snap_t        q_in;
    logic             q_pop;
    logic             q_valid;
    twc_snap_t        q_out;
    logic [CNT_W-1:0] q_count;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{pixel_format: DEF_FORMAT, frame_width: DEF_WIDTH,
                         frame_height: DEF_HEIGHT, intensity_threshold: DEF_THRESHOLD,
                         min_bright_pixels: DEF_MIN_COUNT, confidence_gain: DEF_GAIN};
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_FORMAT:    cfg_reg.pixel_format        <= cfg_wdata[1:0];
                CFG_WIDTH:     cfg_reg.frame_width         <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT:    cfg_reg.frame_height        <= cfg_wdata[DIM_W-1:0];
                CFG_THRESHOLD: cfg_reg.intensity_threshold <= cfg_wdata[7:0];
                CFG_MIN_COUNT: cfg_reg.min_bright_pixels   <= cfg_wdata[BRIGHT_W-1:0];
                CFG_GAIN:      cfg_reg.confidence_gain     <= cfg_wdata[GAIN_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Leave room in the queue for a frame end still in the front pipeline
    assign s_ready = (32'(q_count) + 32'(last_pending)) < QUEUE_DEPTH;
    assign accept  = s_valid && s_ready;

    twc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_data      (s_data),
        .cfg          (cfg_reg),
        .last_pending (last_pending),
        .push         (q_push),
        .snap         (q_in)
    );

    twc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_out),
        .count     (q_count)
    );

    twc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A frame end never lands in a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |-> (32'(q_count) < QUEUE_DEPTH))
        else $error("frame totals pushed into a full queue");

    // The back only takes a frame that is there
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_count != '0))
        else $error("queue popped while empty");

    // An untrusted frame reports all zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |->
            (m_data.centre_x == '0 && m_data.centre_y == '0 && m_data.confidence == '0))
        else $error("nonzero estimate without found");

    // Confidence never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.confidence <= CONF_ONE))
        else $error("confidence above one");

endmodule
